// ----- src/mhic_pkg.sv -----
// Package for the magnetometer hard-iron calibrator.
// Holds the shared types, field widths and fixed arithmetic constants.
// Has no dependencies.
package mhic_pkg;

    localparam int RAW_W         = 16;
    localparam int ASA_W         = 8;
    localparam int OFF_W         = 18;
    localparam int FIELD_W       = 25;
    localparam int CFG_W         = 18;
    localparam int CFG_ADDR_W    = 3;
    localparam int NUM_AXES      = 3;
    localparam int STATUS_READY_BIT = 0;

    // Scale factors 150*(asa+128) and 5*(asa+128), held per lane.
    localparam int K150_W = 16;
    localparam int K5_W   = 11;
    localparam logic [ASA_W:0]    ASA_BIAS = 9'd128;
    localparam logic [K150_W-1:0] K150_MUL = 16'd150;
    localparam logic [K5_W-1:0]   K5_MUL   = 11'd5;
    localparam logic [K150_W-1:0] K150_RST = 16'd38400;
    localparam logic [K5_W-1:0]   K5_RST   = 11'd1280;

    // Offset = trunc(5*k*(min+max) / 1024).
    localparam int OFF_SHIFT = 10;
    // 15360 = 2^14 - 2^10.
    localparam int NOFF_SH_HI = 14;
    localparam int NOFF_SH_LO = 10;
    // Numerator is divided by 256*n: shift by 8, then divide by n.
    localparam int DIV_SHIFT = 8;
    // Extra numerator bits beyond the running sum width.
    localparam int NUM_MARGIN = 19;
    // Quotient bits retired per divider cycle.
    localparam int DIV_STEP_BITS = 3;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_ASA_X = 3'd0,
        CFG_ASA_Y = 3'd1,
        CFG_ASA_Z = 3'd2,
        CFG_OFF_X = 3'd3,
        CFG_OFF_Y = 3'd4,
        CFG_OFF_Z = 3'd5
    } t_cfg_addr;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL1,
        S_OFFS,
        S_MUL2,
        S_NUM,
        S_DIVGO,
        S_DIV,
        S_OUT
    } t_state;

    typedef struct packed {
        logic upd;
        logic full;
        logic mul1;
        logic offs;
        logic recalc;
        logic mul2;
        logic numc;
        logic div_go;
    } t_lane_ctl;

    typedef struct packed {
        logic             asa_we;
        logic             off_we;
        logic [CFG_W-1:0] data;
    } t_cfg_wr;

endpackage

// ----- src/magnetometer_hard_iron_calibrator.sv -----
// Magnetometer hard-iron calibrator, top level: config decode, three axis
// lanes, shared sequencer and the merged output register.
// A ready frame steps through the multiply, offset, numerator and divide states,
// then waits for a free output register; the input stays stalled throughout, and
// the next frame can be taken in the same cycle its result appears at the output.
// Frames with the ready bit clear are dropped. Synchronous reset clears all control state.
module magnetometer_hard_iron_calibrator #(
    parameter int AVG_DEPTH     = 4,
    parameter int RECALC_PERIOD = 10
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [mhic_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [mhic_pkg::CFG_W-1:0]          i_cfg_wdata,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [7:0]                          i_status,
    input  logic [7:0]                          i_x_low,
    input  logic [7:0]                          i_x_high,
    input  logic [7:0]                          i_y_low,
    input  logic [7:0]                          i_y_high,
    input  logic [7:0]                          i_z_low,
    input  logic [7:0]                          i_z_high,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [mhic_pkg::FIELD_W-1:0] o_field_x,
    output logic signed [mhic_pkg::FIELD_W-1:0] o_field_y,
    output logic signed [mhic_pkg::FIELD_W-1:0] o_field_z,
    output logic signed [mhic_pkg::OFF_W-1:0]   o_offset_x,
    output logic signed [mhic_pkg::OFF_W-1:0]   o_offset_y,
    output logic signed [mhic_pkg::OFF_W-1:0]   o_offset_z
);
    import mhic_pkg::*;

    localparam int SUM_W = RAW_W + $clog2(AVG_DEPTH);
    localparam int N_W   = $clog2(AVG_DEPTH + 1);
    localparam int PTR_W = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
    localparam int DEC_W = (RECALC_PERIOD > 1) ? $clog2(RECALC_PERIOD) : 1;
    localparam int NUM_W = SUM_W + NUM_MARGIN;

    t_cfg_wr            cfg_wr    [NUM_AXES];
    t_lane_ctl          lane_ctl;
    logic [PTR_W-1:0]   ring_ptr;
    logic [N_W-1:0]     ring_fill;
    logic [7:0]         axis_low  [NUM_AXES];
    logic [7:0]         axis_high [NUM_AXES];
    logic [NUM_AXES-1:0] lane_done;
    logic signed [FIELD_W-1:0] lane_field  [NUM_AXES];
    logic signed [OFF_W-1:0]   lane_offset [NUM_AXES];
    logic               out_free;
    logic               load_out;

    logic                      r_out_valid;
    logic signed [FIELD_W-1:0] r_field  [NUM_AXES];
    logic signed [OFF_W-1:0]   r_offset [NUM_AXES];

    always_comb begin
        for (int a = 0; a < NUM_AXES; a++) begin
            cfg_wr[a].asa_we = 1'b0;
            cfg_wr[a].off_we = 1'b0;
            cfg_wr[a].data   = i_cfg_wdata;
        end
        unique case (i_cfg_addr)
            CFG_ASA_X: cfg_wr[0].asa_we = i_cfg_wr_en;
            CFG_ASA_Y: cfg_wr[1].asa_we = i_cfg_wr_en;
            CFG_ASA_Z: cfg_wr[2].asa_we = i_cfg_wr_en;
            CFG_OFF_X: cfg_wr[0].off_we = i_cfg_wr_en;
            CFG_OFF_Y: cfg_wr[1].off_we = i_cfg_wr_en;
            CFG_OFF_Z: cfg_wr[2].off_we = i_cfg_wr_en;
            default: begin
            end
        endcase
    end

    assign axis_low[0]  = i_x_low;
    assign axis_high[0] = i_x_high;
    assign axis_low[1]  = i_y_low;
    assign axis_high[1] = i_y_high;
    assign axis_low[2]  = i_z_low;
    assign axis_high[2] = i_z_high;

    mhic_ctrl #(
        .AVG_DEPTH     (AVG_DEPTH),
        .RECALC_PERIOD (RECALC_PERIOD),
        .N_W           (N_W),
        .PTR_W         (PTR_W),
        .DEC_W         (DEC_W)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_ready_bit  (i_status[STATUS_READY_BIT]),
        .i_lanes_done (&lane_done),
        .i_out_free   (out_free),
        .o_in_stall   (o_in_stall),
        .o_ctl        (lane_ctl),
        .o_ptr        (ring_ptr),
        .o_fill       (ring_fill),
        .o_load_out   (load_out)
    );

    for (genvar g = 0; g < NUM_AXES; g++) begin : g_lane
        mhic_lane #(
            .AVG_DEPTH (AVG_DEPTH),
            .SUM_W     (SUM_W),
            .N_W       (N_W),
            .PTR_W     (PTR_W),
            .NUM_W     (NUM_W)
        ) u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_cfg    (cfg_wr[g]),
            .i_ctl    (lane_ctl),
            .i_ptr    (ring_ptr),
            .i_fill   (ring_fill),
            .i_low    (axis_low[g]),
            .i_high   (axis_high[g]),
            .o_done   (lane_done[g]),
            .o_field  (lane_field[g]),
            .o_offset (lane_offset[g])
        );
    end

    // The output register frees up in the same cycle its transaction completes.
    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            for (int a = 0; a < NUM_AXES; a++) begin
                r_field[a]  <= lane_field[a];
                r_offset[a] <= lane_offset[a];
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_field_x   = r_field[0];
    assign o_field_y   = r_field[1];
    assign o_field_z   = r_field[2];
    assign o_offset_x  = r_offset[0];
    assign o_offset_y  = r_offset[1];
    assign o_offset_z  = r_offset[2];

    // A ready frame blocks further input until its result is registered.
    a_ready_frame_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_status[STATUS_READY_BIT]) |=> o_in_stall)
        else $error("input not stalled after a ready frame");

    // The three lanes run in lockstep and finish their divisions together.
    a_lanes_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (lane_done[0] == lane_done[1]) && (lane_done[1] == lane_done[2]))
        else $error("axis lanes finished out of step");

    // A result is only merged into a free output register, and then shows up.
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |-> out_free ##1 o_out_valid)
        else $error("output register loaded while occupied");

    // A frame with the ready bit clear does not start processing or stall the input.
    a_idle_frame_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && !i_status[STATUS_READY_BIT]) |=> !o_in_stall)
        else $error("frame without ready bit started processing");

endmodule

// ----- src/mhic_div.sv -----
// Iterative unsigned divider, DIV_STEP_BITS quotient bits per cycle.
// Used by each axis lane to divide the shifted numerator by the sample count.
// Depends on mhic_pkg.
module mhic_div #(
    parameter int DVD_W = 29,
    parameter int DVS_W = 3
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DVD_W-1:0] o_quotient
);
    import mhic_pkg::*;

    localparam int STEPS = (DVD_W + DIV_STEP_BITS - 1) / DIV_STEP_BITS;
    localparam int DIV_W = STEPS * DIV_STEP_BITS;
    localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;

    logic [DIV_W-1:0] r_quo, n_quo;
    logic [DVS_W-1:0] r_rem, n_rem;
    logic [DVS_W-1:0] r_dvs;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    always_comb begin
        logic [DVS_W:0] trial;
        n_rem = r_rem;
        n_quo = r_quo;
        trial = '0;
        for (int k = 0; k < DIV_STEP_BITS; k++) begin
            trial = {n_rem, n_quo[DIV_W-1]};
            n_quo = {n_quo[DIV_W-2:0], 1'b0};
            if (trial >= {1'b0, r_dvs}) begin
                trial    = trial - {1'b0, r_dvs};
                n_quo[0] = 1'b1;
            end
            n_rem = trial[DVS_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == CNT_W'(STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= DIV_W'(i_dividend);
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo[DVD_W-1:0];

endmodule

// ----- src/mhic_lane.sv -----
// One axis lane: sample ring with running sum, extrema, offset and field math.
// Three copies run side by side under the shared sequencer.
// Depends on mhic_pkg and mhic_div.
module mhic_lane #(
    parameter int AVG_DEPTH = 4,
    parameter int SUM_W     = 18,
    parameter int N_W       = 3,
    parameter int PTR_W     = 2,
    parameter int NUM_W     = 37
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  mhic_pkg::t_cfg_wr                     i_cfg,
    input  mhic_pkg::t_lane_ctl                   i_ctl,
    input  logic [PTR_W-1:0]                      i_ptr,
    input  logic [N_W-1:0]                        i_fill,
    input  logic [7:0]                            i_low,
    input  logic [7:0]                            i_high,
    output logic                                  o_done,
    output logic signed [mhic_pkg::FIELD_W-1:0]   o_field,
    output logic signed [mhic_pkg::OFF_W-1:0]     o_offset
);
    import mhic_pkg::*;

    localparam int PS_W  = SUM_W + K150_W + 1;
    localparam int EXT_W = RAW_W + 1 + K5_W + 1;
    localparam int PN_W  = OFF_W + N_W + 1;
    localparam int Q_W   = NUM_W - DIV_SHIFT;

    logic signed [RAW_W-1:0]  raw;
    logic signed [RAW_W-1:0]  old_sample;
    logic signed [SUM_W-1:0]  old_term;
    logic signed [SUM_W-1:0]  n_sum;
    logic signed [RAW_W:0]    ext_sum;
    logic signed [EXT_W-1:0]  off_adj;
    logic signed [NUM_W-1:0]  noff_ext;
    logic signed [NUM_W-1:0]  n_num;
    logic [NUM_W-1:0]         num_mag;
    logic [ASA_W:0]           asa_k;
    logic [Q_W-1:0]           quo;
    logic signed [Q_W:0]      quo_s;

    logic signed [RAW_W-1:0]  r_ring [AVG_DEPTH];
    logic signed [SUM_W-1:0]  r_sum;
    logic signed [RAW_W-1:0]  r_min;
    logic signed [RAW_W-1:0]  r_max;
    logic signed [OFF_W-1:0]  r_off;
    logic [K150_W-1:0]        r_k150;
    logic [K5_W-1:0]          r_k5;
    logic signed [PS_W-1:0]   r_p_sum;
    logic signed [EXT_W-1:0]  r_p_ext;
    logic signed [PN_W-1:0]   r_p_noff;
    logic signed [NUM_W-1:0]  r_num;
    logic                     r_neg;

    assign raw        = $signed({i_high, i_low});
    assign old_sample = r_ring[i_ptr];
    assign old_term   = i_ctl.full ? SUM_W'(old_sample) : SUM_W'(0);
    assign n_sum      = r_sum + SUM_W'(raw) - old_term;
    assign ext_sum    = (RAW_W + 1)'(r_min) + (RAW_W + 1)'(r_max);
    assign asa_k      = {1'b0, i_cfg.data[ASA_W-1:0]} + ASA_BIAS;

    // Bias a negative product by 2^10 - 1 so the shift truncates toward zero.
    assign off_adj = r_p_ext
                   + $signed({{(EXT_W - OFF_SHIFT){1'b0}}, {OFF_SHIFT{r_p_ext[EXT_W-1]}}});

    assign noff_ext = NUM_W'(r_p_noff);
    assign n_num    = NUM_W'(r_p_sum) - (noff_ext <<< NOFF_SH_HI)
                    + (noff_ext <<< NOFF_SH_LO);
    assign num_mag  = r_num[NUM_W-1] ? NUM_W'(-r_num) : NUM_W'(r_num);

    mhic_div #(
        .DVD_W (Q_W),
        .DVS_W (N_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_ctl.div_go),
        .i_dividend (num_mag[NUM_W-1:DIV_SHIFT]),
        .i_divisor  (i_fill),
        .o_done     (o_done),
        .o_quotient (quo)
    );

    assign quo_s    = r_neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
    assign o_field  = quo_s[FIELD_W-1:0];
    assign o_offset = r_off;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum  <= '0;
            r_min  <= '0;
            r_max  <= '0;
            r_off  <= '0;
            r_k150 <= K150_RST;
            r_k5   <= K5_RST;
        end else begin
            if (i_cfg.asa_we) begin
                r_k150 <= K150_W'(asa_k * K150_MUL);
                r_k5   <= K5_W'(asa_k * K5_MUL);
            end
            if (i_cfg.off_we) begin
                r_off <= $signed(i_cfg.data[OFF_W-1:0]);
            end
            if (i_ctl.upd) begin
                r_sum <= n_sum;
                // An extremum of zero counts as unset and is always replaced.
                if (raw < r_min || r_min == '0) begin
                    r_min <= raw;
                end
                if (raw > r_max || r_max == '0) begin
                    r_max <= raw;
                end
            end
            if (i_ctl.offs && i_ctl.recalc) begin
                r_off <= off_adj[OFF_SHIFT+OFF_W-1:OFF_SHIFT];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.upd) begin
            r_ring[i_ptr] <= raw;
        end
        if (i_ctl.mul1) begin
            r_p_sum <= $signed({1'b0, r_k150}) * r_sum;
            r_p_ext <= $signed({1'b0, r_k5}) * ext_sum;
        end
        if (i_ctl.mul2) begin
            r_p_noff <= r_off * $signed({1'b0, i_fill});
        end
        if (i_ctl.numc) begin
            r_num <= n_num;
        end
        if (i_ctl.div_go) begin
            r_neg <= r_num[NUM_W-1];
        end
    end

endmodule

// ----- src/mhic_ctrl.sv -----
// Shared sequencer: ring pointer, fill count, recalculation counter and the
// step-by-step control of the three axis lanes. Depends on mhic_pkg.
module mhic_ctrl #(
    parameter int AVG_DEPTH     = 4,
    parameter int RECALC_PERIOD = 10,
    parameter int N_W           = 3,
    parameter int PTR_W         = 2,
    parameter int DEC_W         = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_ready_bit,
    input  logic                i_lanes_done,
    input  logic                i_out_free,
    output logic                o_in_stall,
    output mhic_pkg::t_lane_ctl o_ctl,
    output logic [PTR_W-1:0]    o_ptr,
    output logic [N_W-1:0]      o_fill,
    output logic                o_load_out
);
    import mhic_pkg::*;

    t_state           r_state, n_state;
    logic [PTR_W-1:0] r_ptr, n_ptr;
    logic [N_W-1:0]   r_fill, n_fill;
    logic [DEC_W-1:0] r_dec, n_dec;
    logic             r_recalc, n_recalc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ptr    <= '0;
            r_fill   <= '0;
            r_dec    <= '0;
            r_recalc <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ptr    <= n_ptr;
            r_fill   <= n_fill;
            r_dec    <= n_dec;
            r_recalc <= n_recalc;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_ctl      = '0;
        o_load_out = 1'b0;
        o_ctl.full   = (r_fill == N_W'(AVG_DEPTH));
        o_ctl.recalc = r_recalc;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && i_ready_bit) begin
                    o_ctl.upd = 1'b1;
                    n_state   = S_MUL1;
                end
            end
            S_MUL1: begin
                o_ctl.mul1 = 1'b1;
                n_state    = S_OFFS;
            end
            S_OFFS: begin
                o_ctl.offs = 1'b1;
                n_state    = S_MUL2;
            end
            S_MUL2: begin
                o_ctl.mul2 = 1'b1;
                n_state    = S_NUM;
            end
            S_NUM: begin
                o_ctl.numc = 1'b1;
                n_state    = S_DIVGO;
            end
            S_DIVGO: begin
                o_ctl.div_go = 1'b1;
                n_state      = S_DIV;
            end
            S_DIV: begin
                if (i_lanes_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_out_free) begin
                    o_load_out = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_ptr    = r_ptr;
        n_fill   = r_fill;
        n_dec    = r_dec;
        n_recalc = r_recalc;
        if (o_ctl.upd) begin
            n_ptr = (r_ptr == PTR_W'(AVG_DEPTH - 1)) ? '0 : r_ptr + 1'b1;
            if (r_fill != N_W'(AVG_DEPTH)) begin
                n_fill = r_fill + 1'b1;
            end
            n_recalc = (r_dec == DEC_W'(RECALC_PERIOD - 1));
            n_dec    = n_recalc ? '0 : r_dec + 1'b1;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);
    assign o_ptr      = r_ptr;
    assign o_fill     = r_fill;

endmodule
